FILE: hw/rtl/planar_tile_to_nibble_texture_top_assert.svh
// ----------------------------------------------------------------------------
// planar_tile_to_nibble_texture_top_assert
// assertion macros for the texture updater
// ----------------------------------------------------------------------------
`ifndef PLANAR_TILE_TO_NIBBLE_TEXTURE_TOP_ASSERT_SVH
`define PLANAR_TILE_TO_NIBBLE_TEXTURE_TOP_ASSERT_SVH

// checked out of reset only
`define PTNT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked on every edge
`define PTNT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

FILE: hw/rtl/ptnt_pkg.sv
// ----------------------------------------------------------------------------
// ptnt_pkg
// constants and bit-scatter functions for the planar to packed texture updater
// ----------------------------------------------------------------------------
package ptnt_pkg;

  localparam int unsigned VRAM_ADDR_BITS = 16;
  localparam int unsigned VRAM_DATA_W    = 16;

  localparam int unsigned BG_IDX_W  = VRAM_ADDR_BITS - 1;
  localparam int unsigned SPR_IDX_W = VRAM_ADDR_BITS - 2;
  localparam int unsigned BG_DEPTH  = 1 << BG_IDX_W;
  localparam int unsigned SPR_DEPTH = 1 << SPR_IDX_W;

  localparam int unsigned BG_WORD_W  = 32;
  localparam int unsigned SPR_WORD_W = 64;
  localparam int unsigned BG_PIX     = BG_WORD_W / 4;
  localparam int unsigned SPR_PIX    = SPR_WORD_W / 4;

  localparam int unsigned BG_INDEX_FIELD_W  = 15;
  localparam int unsigned SPR_INDEX_FIELD_W = 14;

  localparam int unsigned S_TDATA_W = 32;
  localparam int unsigned M_FIELDS_W =
    BG_INDEX_FIELD_W + BG_WORD_W + SPR_INDEX_FIELD_W + SPR_WORD_W;
  localparam int unsigned M_TDATA_W = ((M_FIELDS_W + 7) / 8) * 8;

  localparam int unsigned OUT_BG_WORD_LSB   = BG_INDEX_FIELD_W;
  localparam int unsigned OUT_SPR_INDEX_LSB = OUT_BG_WORD_LSB + BG_WORD_W;
  localparam int unsigned OUT_SPR_WORD_LSB  = OUT_SPR_INDEX_LSB + SPR_INDEX_FIELD_W;

  function automatic logic [BG_IDX_W-1:0] bg_index_of(
    input logic [VRAM_ADDR_BITS-1:0] a
  );
    return {a[VRAM_ADDR_BITS-1:6], a[2:0], a[5:4]};
  endfunction

  function automatic logic [SPR_IDX_W-1:0] spr_index_of(
    input logic [VRAM_ADDR_BITS-1:0] a
  );
    return {a[VRAM_ADDR_BITS-1:6], a[2:0], a[3]};
  endfunction

  // pixel k takes data bits 7-k and 15-k into planes 0/1 or 2/3
  function automatic logic [BG_WORD_W-1:0] bg_merge(
    input logic [BG_WORD_W-1:0]   old,
    input logic [VRAM_DATA_W-1:0] d,
    input logic                   high_pair
  );
    logic [BG_WORD_W-1:0] w;
    w = old;
    for (int k = 0; k < BG_PIX; k++) begin
      if (high_pair) begin
        w[4*k+2] = d[7-k];
        w[4*k+3] = d[15-k];
      end else begin
        w[4*k]   = d[7-k];
        w[4*k+1] = d[15-k];
      end
    end
    return w;
  endfunction

  // pixel k takes data bit 15-k into the selected plane
  function automatic logic [SPR_WORD_W-1:0] spr_merge(
    input logic [SPR_WORD_W-1:0]  old,
    input logic [VRAM_DATA_W-1:0] d,
    input logic [1:0]             plane
  );
    logic [SPR_WORD_W-1:0] w;
    w = old;
    for (int k = 0; k < SPR_PIX; k++) begin
      w[4*k+plane] = d[15-k];
    end
    return w;
  endfunction

endpackage

FILE: hw/rtl/planar_tile_to_nibble_texture_top.sv
// pipeline: an accepted request passes the s1 stage registers, then the output register behind m_axis_tvalid_o
// throughput: one request per cycle while the output is not stalled, set by the single
//   read and write port of each texture memory, with same-index back-to-back writes forwarded
// reset: after rst_ni a clearing pass zeroes every entry of both memories,
//   s_axis_tready_o stays low until it is done
// ----------------------------------------------------------------------------
// planar_tile_to_nibble_texture_top
// scatters bitplane bits of a video ram write into two packed 4bpp texture stores
// ----------------------------------------------------------------------------
`include "planar_tile_to_nibble_texture_top_assert.svh"

module planar_tile_to_nibble_texture_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // vram_addr, vram_data
  input  logic [ptnt_pkg::S_TDATA_W-1:0] s_axis_tdata_i,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // bg_index, bg_word, spr_index, spr_word, zero pad
  output logic [ptnt_pkg::M_TDATA_W-1:0] m_axis_tdata_o
);
  import ptnt_pkg::*;

  logic [BG_WORD_W-1:0]  bg_mem  [BG_DEPTH];
  logic [SPR_WORD_W-1:0] spr_mem [SPR_DEPTH];

  logic                      clr_q;
  logic [BG_IDX_W-1:0]       clr_cnt_q;

  logic [VRAM_ADDR_BITS-1:0] in_addr;
  logic [VRAM_DATA_W-1:0]    in_data;
  logic [BG_IDX_W-1:0]       in_bi;
  logic [SPR_IDX_W-1:0]      in_si;
  logic                      s_acc;

  logic                      s1_valid_q;
  logic [BG_IDX_W-1:0]       s1_bi_q;
  logic [SPR_IDX_W-1:0]      s1_si_q;
  logic [VRAM_DATA_W-1:0]    s1_data_q;
  logic                      s1_hi_q;
  logic [1:0]                s1_plane_q;
  logic                      s1_fwd_bg_q;
  logic                      s1_fwd_spr_q;
  logic                      s1_adv;

  logic [BG_WORD_W-1:0]      bg_rd_q;
  logic [SPR_WORD_W-1:0]     spr_rd_q;
  logic [BG_WORD_W-1:0]      lw_bg_q;
  logic [SPR_WORD_W-1:0]     lw_spr_q;
  logic [BG_WORD_W-1:0]      bg_old;
  logic [SPR_WORD_W-1:0]     spr_old;
  logic [BG_WORD_W-1:0]      bg_new;
  logic [SPR_WORD_W-1:0]     spr_new;

  logic                      bg_we;
  logic [BG_IDX_W-1:0]       bg_wa;
  logic [BG_WORD_W-1:0]      bg_wd;
  logic [SPR_IDX_W-1:0]      spr_wa;
  logic [SPR_WORD_W-1:0]     spr_wd;

  logic                      out_valid_q;
  logic [M_TDATA_W-1:0]      out_data_q;
  logic [M_TDATA_W-1:0]      out_data_d;

  assign in_addr = s_axis_tdata_i[VRAM_ADDR_BITS-1:0];
  assign in_data = s_axis_tdata_i[16 +: VRAM_DATA_W];
  assign in_bi   = bg_index_of(in_addr);
  assign in_si   = spr_index_of(in_addr);

  assign s1_adv          = s1_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !clr_q && (!s1_valid_q || s1_adv);
  assign s_acc           = s_axis_tvalid_i && s_axis_tready_o;

  // read data is stale when the previous item wrote the same entry during the read
  assign bg_old  = s1_fwd_bg_q  ? lw_bg_q  : bg_rd_q;
  assign spr_old = s1_fwd_spr_q ? lw_spr_q : spr_rd_q;
  assign bg_new  = bg_merge(bg_old, s1_data_q, s1_hi_q);
  assign spr_new = spr_merge(spr_old, s1_data_q, s1_plane_q);

  assign bg_we  = clr_q || s1_adv;
  assign bg_wa  = clr_q ? clr_cnt_q : s1_bi_q;
  assign bg_wd  = clr_q ? '0 : bg_new;
  assign spr_wa = clr_q ? clr_cnt_q[SPR_IDX_W-1:0] : s1_si_q;
  assign spr_wd = clr_q ? '0 : spr_new;

  always_comb begin
    out_data_d = '0;
    out_data_d[BG_INDEX_FIELD_W-1:0]                  = BG_INDEX_FIELD_W'(s1_bi_q);
    out_data_d[OUT_BG_WORD_LSB +: BG_WORD_W]          = bg_new;
    out_data_d[OUT_SPR_INDEX_LSB +: SPR_INDEX_FIELD_W] = SPR_INDEX_FIELD_W'(s1_si_q);
    out_data_d[OUT_SPR_WORD_LSB +: SPR_WORD_W]        = spr_new;
  end

  always_ff @(posedge clk_i) begin
    if (bg_we) begin
      bg_mem[bg_wa]   <= bg_wd;
      spr_mem[spr_wa] <= spr_wd;
    end
    if (s_acc) begin
      bg_rd_q  <= bg_mem[in_bi];
      spr_rd_q <= spr_mem[in_si];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= 1'b1;
      clr_cnt_q   <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (clr_q) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
        if (&clr_cnt_q) begin
          clr_q <= 1'b0;
        end
      end
      if (s_acc) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      s1_bi_q      <= in_bi;
      s1_si_q      <= in_si;
      s1_data_q    <= in_data;
      s1_hi_q      <= in_addr[3];
      s1_plane_q   <= in_addr[5:4];
      s1_fwd_bg_q  <= s1_adv && (s1_bi_q == in_bi);
      s1_fwd_spr_q <= s1_adv && (s1_si_q == in_si);
    end
    if (s1_adv) begin
      lw_bg_q    <= bg_new;
      lw_spr_q   <= spr_new;
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  `PTNT_ASSERT(a_no_out_in_clear, clr_q |-> !out_valid_q && !s1_valid_q,
    "result pending during clearing pass")
  `PTNT_ASSERT(a_fwd_bg, s_acc && s1_adv && (s1_bi_q == in_bi) |=> s1_fwd_bg_q,
    "background same-index write not forwarded")
  `PTNT_ASSERT(a_fwd_spr, s_acc && s1_adv && (s1_si_q == in_si) |=> s1_fwd_spr_q,
    "sprite same-index write not forwarded")
  `PTNT_ASSERT_ALWAYS(a_reset_clear, !rst_ni |=> clr_q || !rst_ni,
    "clearing pass not started by reset")

endmodule
